@@ sv/lcdx_pkg.sv @@
package lcdx_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 24;

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] CFG_EIGHT_BIT  = 3'd0;
    localparam logic [CfgAddrW-1:0] CFG_SELECT_PIN = 3'd1;
    localparam logic [CfgAddrW-1:0] CFG_STROBE_PIN = 3'd2;
    localparam logic [CfgAddrW-1:0] CFG_RW_PIN     = 3'd3;
    localparam logic [CfgAddrW-1:0] CFG_DATA_MAP   = 3'd4;

    // Request operation codes.
    localparam logic [1:0] MODE_CMD    = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_NIBBLE = 2'd2;
    localparam logic [1:0] MODE_PIN    = 2'd3;

    typedef logic [2:0] t_kind;

    // Which pin a step drives, and from where its level comes.
    localparam t_kind KIND_SELECT    = 3'd0;
    localparam t_kind KIND_RW        = 3'd1;
    localparam t_kind KIND_LINE      = 3'd2;
    localparam t_kind KIND_STROBE_LO = 3'd3;
    localparam t_kind KIND_STROBE_HI = 3'd4;
    localparam t_kind KIND_PIN       = 3'd5;

    typedef struct packed {
        logic       load;
        logic       step;
        t_kind      kind;
        logic [2:0] line;
        logic [2:0] dbit;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic eight_bit;
        logic rw_wired;
        logic out_free;
    } t_status;

endpackage

@@ sv/lcdx_dp.sv @@
module lcdx_dp
    import lcdx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_value,
    input  logic [2:0]          i_pin,
    input  logic                i_level,
    input  t_cmd                i_cmd,
    output t_status             o_status,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [7:0]          o_expander_byte,
    output logic                o_last
);

    logic                r_eight_bit;
    logic [2:0]          r_select_pin;
    logic [2:0]          r_strobe_pin;
    logic [3:0]          r_rw_pin;
    logic [CfgDataW-1:0] r_data_map;

    logic [1:0] r_mode;
    logic [7:0] r_value;
    logic [2:0] r_pin;
    logic       r_level;

    logic [7:0] r_shadow;
    logic [7:0] n_shadow;
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic [7:0][2:0] w_map;
    logic [2:0]      w_bit;
    logic            w_lvl;

    assign w_map = r_data_map;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eight_bit  <= 1'b0;
            r_select_pin <= 3'd1;
            r_strobe_pin <= 3'd2;
            r_rw_pin     <= 4'd8;
            r_data_map   <= 24'd1838;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_EIGHT_BIT:  r_eight_bit  <= i_cfg_data[0];
                CFG_SELECT_PIN: r_select_pin <= i_cfg_data[2:0];
                CFG_STROBE_PIN: r_strobe_pin <= i_cfg_data[2:0];
                CFG_RW_PIN:     r_rw_pin     <= i_cfg_data[3:0];
                CFG_DATA_MAP:   r_data_map   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
            r_pin   <= i_pin;
            r_level <= i_level;
        end
    end

    always_comb begin
        unique case (i_cmd.kind)
            KIND_SELECT: begin
                w_bit = r_select_pin;
                w_lvl = r_mode[0];
            end
            KIND_RW: begin
                w_bit = r_rw_pin[2:0];
                w_lvl = 1'b0;
            end
            KIND_LINE: begin
                w_bit = w_map[i_cmd.line];
                w_lvl = r_value[i_cmd.dbit];
            end
            KIND_STROBE_LO: begin
                w_bit = r_strobe_pin;
                w_lvl = 1'b0;
            end
            KIND_STROBE_HI: begin
                w_bit = r_strobe_pin;
                w_lvl = 1'b1;
            end
            KIND_PIN: begin
                w_bit = r_pin;
                w_lvl = r_level;
            end
            default: begin
                w_bit = r_select_pin;
                w_lvl = r_mode[0];
            end
        endcase
        n_shadow        = r_shadow;
        n_shadow[w_bit] = w_lvl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shadow    <= 8'd0;
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_shadow    <= n_shadow;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_out_byte <= n_shadow;
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.eight_bit = r_eight_bit;
    assign o_status.rw_wired  = ~r_rw_pin[3];
    assign o_status.out_free  = ~r_out_valid | i_ready;

    assign o_valid         = r_out_valid;
    assign o_expander_byte = r_out_byte;
    assign o_last          = r_out_last;

endmodule

@@ sv/lcdx_ctrl.sv @@
module lcdx_ctrl
    import lcdx_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_mode,
    output logic       o_ready,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SELECT = 3'd1;
    localparam logic [2:0] ST_RW     = 3'd2;
    localparam logic [2:0] ST_LINE   = 3'd3;
    localparam logic [2:0] ST_STB0   = 3'd4;
    localparam logic [2:0] ST_STB1   = 3'd5;
    localparam logic [2:0] ST_STB2   = 3'd6;
    localparam logic [2:0] ST_PIN    = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] r_line;
    logic [2:0] n_line;
    logic       r_wide;
    logic       n_wide;
    logic       r_hi;
    logic       n_hi;

    logic w_accept;
    logic w_step;
    logic w_line_end;

    assign o_ready    = (r_state == ST_IDLE);
    assign w_accept   = o_ready & i_valid;
    assign w_step     = (r_state != ST_IDLE) & i_status.out_free;
    assign w_line_end = r_wide ? (r_line == 3'd7) : (r_line == 3'd3);

    always_comb begin
        n_state = r_state;
        n_line  = r_line;
        n_wide  = r_wide;
        n_hi    = r_hi;
        if (w_accept) begin
            n_line = 3'd0;
            unique case (i_mode)
                MODE_CMD, MODE_DATA: begin
                    n_state = ST_SELECT;
                    n_wide  = i_status.eight_bit;
                    n_hi    = ~i_status.eight_bit;
                end
                MODE_NIBBLE: begin
                    n_state = ST_LINE;
                    n_wide  = 1'b0;
                    n_hi    = 1'b0;
                end
                MODE_PIN: begin
                    n_state = ST_PIN;
                end
                default: begin
                    n_state = ST_PIN;
                end
            endcase
        end else if (w_step) begin
            unique case (r_state)
                ST_SELECT: n_state = i_status.rw_wired ? ST_RW : ST_LINE;
                ST_RW:     n_state = ST_LINE;
                ST_LINE: begin
                    if (w_line_end) begin
                        n_state = ST_STB0;
                    end else begin
                        n_line = r_line + 3'd1;
                    end
                end
                ST_STB0: n_state = ST_STB1;
                ST_STB1: n_state = ST_STB2;
                ST_STB2: begin
                    // When the high nibble is done, the low nibble follows; otherwise the request ends.
                    if (r_hi) begin
                        n_state = ST_LINE;
                        n_hi    = 1'b0;
                        n_line  = 3'd0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
                ST_PIN:  n_state = ST_IDLE;
                default: n_state = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_line  <= 3'd0;
            r_wide  <= 1'b0;
            r_hi    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_line  <= n_line;
            r_wide  <= n_wide;
            r_hi    <= n_hi;
        end
    end

    always_comb begin
        o_cmd.load = w_accept;
        o_cmd.step = w_step;
        o_cmd.line = r_line;
        o_cmd.dbit = r_wide ? r_line : {r_hi, r_line[1:0]};
        o_cmd.last = ((r_state == ST_STB2) & ~r_hi) | (r_state == ST_PIN);
        unique case (r_state)
            ST_SELECT: o_cmd.kind = KIND_SELECT;
            ST_RW:     o_cmd.kind = KIND_RW;
            ST_LINE:   o_cmd.kind = KIND_LINE;
            ST_STB1:   o_cmd.kind = KIND_STROBE_HI;
            ST_STB0,
            ST_STB2:   o_cmd.kind = KIND_STROBE_LO;
            ST_PIN:    o_cmd.kind = KIND_PIN;
            default:   o_cmd.kind = KIND_SELECT;
        endcase
    end

endmodule

@@ sv/char_lcd_expander_sequencer.sv @@
// Character display sequencer behind an 8-bit output expander.
// A request arrives on i_valid/o_ready with i_mode, i_value, i_pin and i_level:
// a command byte, a data byte, a lone nibble or a single pin write. Each pin
// change updates a shadow of the expander pins, and the whole shadow byte is
// presented on o_valid/i_ready with o_last set on the final byte of a request.
// The configuration port (i_cfg_we, i_cfg_addr, i_cfg_data) writes the mode,
// the select, strobe and read/write pin numbers and the data pin map; it
// should only be used while the block is idle.
// The sequencer emits one expander byte per cycle while the receiver keeps
// taking bytes. A byte request gives 12 to 16 results, a lone nibble gives 7
// results and a single pin write 1 result. After a request is accepted, the
// first result passes the controller state register and then the output
// register; the step count of the controller state machine sets these figures.
// A new request is taken as soon as the previous one has issued its last step,
// even while that last byte still waits in the output register. When the
// receiver stalls, the sequencer holds its place until the byte is taken.
// Synchronous reset clears the shadow byte to zero and restores the default
// configuration.
module char_lcd_expander_sequencer
    import lcdx_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgAddrW-1:0] i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_data,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_mode,
    input  logic [7:0]          i_value,
    input  logic [2:0]          i_pin,
    input  logic                i_level,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_expander_byte,
    output logic                o_last
);

    t_cmd    w_cmd;
    t_status w_status;

    lcdx_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    lcdx_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_value         (i_value),
        .i_pin           (i_pin),
        .i_level         (i_level),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_expander_byte (o_expander_byte),
        .o_last          (o_last)
    );

    // Every request causes at least one pin change, so the block is busy next.
    a_busy_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready
    ) else $error("sequencer idle right after accepting a request");

    // While idle, any byte still waiting must be the final one of its request.
    a_idle_pending_is_last: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && o_valid) |-> o_last
    ) else $error("idle with a non-final byte pending");

    // Consecutive results differ in at most one pin.
    a_one_pin_change: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready) |=>
            (!o_valid || $countones(o_expander_byte ^ $past(o_expander_byte)) <= 1)
    ) else $error("more than one expander pin changed between results");

endmodule
